[hw/rtl/rms_current_meter_offset_tracking_macros.svh]
// Assertion macros shared by the rms meter RTL
`ifndef RMS_CURRENT_METER_OFFSET_TRACKING_MACROS_SVH
`define RMS_CURRENT_METER_OFFSET_TRACKING_MACROS_SVH

// same-cycle implication, disabled in reset
`define RCM_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled in reset
`define RCM_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

[hw/rtl/rcm_pkg.sv]
// Types and constants of the rms current meter
`timescale 1ns / 1ps
package rcm_pkg;

  localparam int CH_IN_W    = 2;
  localparam int SMP_IN_W   = 12;
  localparam int IN_DATA_W  = 16;
  localparam int RMS_W      = 24;
  localparam int OUT_DATA_W = 24;

  localparam int CNT_W      = 16;
  localparam int GAIN_W     = 32;
  localparam int GAIN_FRAC  = 16;
  localparam int SUM_W      = 48;
  localparam int FRAC_SHIFT = 12;
  localparam int DIV_W      = SUM_W + FRAC_SHIFT;
  localparam int DIVISOR_W  = CNT_W + 1;
  localparam int ROOT_W     = DIV_W / 2;
  localparam int PROD_W     = ROOT_W + GAIN_W;

  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 32;
  localparam logic [CFG_IDX_W-1:0] CFG_SAMPLE_COUNT = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_CURRENT_GAIN = 1'b1;

  localparam logic [CNT_W-1:0]  SAMPLE_COUNT_RST = 16'd400;
  localparam logic [GAIN_W-1:0] CURRENT_GAIN_RST = 32'd316406;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_FILT,
    ST_FVAL,
    ST_SQ,
    ST_DIV,
    ST_SQRT,
    ST_MUL,
    ST_OUT
  } rcm_state_e;

endpackage

[hw/rtl/rms_current_meter_offset_tracking.sv]
// RMS current meter with per-channel DC offset tracking, top level
//
// Input stream: one ADC sample word per transfer, channel in tuser. Each
// sample moves its channel's DC offset by 1/2^FILTER_SHIFT of the error,
// then the square of sample minus offset is added to a running sum.
// When sample_count samples have been gathered, one word leaves on the
// output stream: gain * sqrt(sum / samples) in 16.8, saturating, with the
// channel of the last sample in tuser.
// Timing: one sample at a time. A sample that closes no burst passes the
// filter states and the bit-serial squarer. The closing sample also runs the
// 60-step divider, 30-step root and 30-step gain multiply, each one bit per
// cycle, and the output load.
// The result waits in an output register; the next sample is taken while it
// waits. A second result stalls the core until the first is taken.
// Reset: offsets to mid-scale, sum and count to zero, registers to defaults.
// Configuration writes are taken any cycle but belong in idle time.
`timescale 1ns / 1ps
`include "rms_current_meter_offset_tracking_macros.svh"
module rms_current_meter_offset_tracking #(
  parameter int CHANNELS     = 4,
  parameter int SAMPLE_BITS  = 12,
  parameter int FILTER_SHIFT = 10
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            s_axis_tvalid_i,
  output logic                            s_axis_tready_o,
  input  logic [rcm_pkg::IN_DATA_W-1:0]   s_axis_tdata_i,  // [11:0] sample
  input  logic [rcm_pkg::CH_IN_W-1:0]     s_axis_tuser_i,  // [1:0] channel
  output logic                            m_axis_tvalid_o,
  input  logic                            m_axis_tready_i,
  output logic [rcm_pkg::OUT_DATA_W-1:0]  m_axis_tdata_o,  // [23:0] rms_value
  output logic [rcm_pkg::CH_IN_W-1:0]     m_axis_tuser_o,  // [1:0] result_channel
  input  logic                            cfg_we_i,
  input  logic [rcm_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [rcm_pkg::CFG_DATA_W-1:0]  cfg_data_i
);

  localparam int OFF_W = SAMPLE_BITS + FILTER_SHIFT;
  localparam int IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int SQ_W  = 2 * SAMPLE_BITS + 4;
  localparam int SQ_SH = 2 * FILTER_SHIFT - 4;
  localparam int SUM_W = rcm_pkg::SUM_W;
  localparam int CNT_W = rcm_pkg::CNT_W;
  localparam int N_W   = rcm_pkg::DIVISOR_W;
  localparam int P_W   = rcm_pkg::PROD_W;
  localparam int RMS_W = rcm_pkg::RMS_W;
  localparam int GF    = rcm_pkg::GAIN_FRAC;
  localparam logic [OFF_W-1:0] OFF_MID = {1'b1, {(OFF_W-1){1'b0}}};

  rcm_pkg::rcm_state_e state_q, state_d;

  logic [CNT_W-1:0]            sample_count_q;
  logic [rcm_pkg::GAIN_W-1:0]  current_gain_q;

  logic [rcm_pkg::CH_IN_W-1:0] ch_q;
  logic [IDX_W-1:0]            idx_q;
  logic [SAMPLE_BITS-1:0]      smp_q;
  logic [OFF_W-1:0]            off_q [CHANNELS];
  logic [OFF_W-1:0]            noff_q;
  logic [SUM_W-1:0]            sum_q;
  logic [CNT_W-1:0]            cnt_q;
  logic [RMS_W-1:0]            res_q;
  logic                        m_valid_q;
  logic [RMS_W-1:0]            m_data_q;
  logic [rcm_pkg::CH_IN_W-1:0] m_user_q;

  logic                        s_acc;
  logic [4:0]                  ch_m;
  logic [rcm_pkg::IN_DATA_W-1:0] smp_ext;
  logic [OFF_W-1:0]            scaled;
  logic [OFF_W-1:0]            off_cur;
  logic [OFF_W:0]              diff;
  logic [OFF_W-1:0]            dmag;
  logic [SAMPLE_BITS-1:0]      step;
  logic [OFF_W-1:0]            noff;
  logic [OFF_W:0]              fval;
  logic [OFF_W-1:0]            fmag;

  logic                        sq_start, sq_done;
  logic [2*OFF_W-1:0]          sq_prod;
  logic [SUM_W:0]              sum_add;
  logic [SUM_W-1:0]            sum_new;
  logic [CNT_W-1:0]            cnt_new;
  logic [CNT_W-1:0]            target;
  logic                        emit;
  logic                        div_start, div_done;
  logic [N_W-1:0]              div_divisor;
  logic [rcm_pkg::DIV_W-1:0]   div_quot;
  logic                        sqrt_start, sqrt_done;
  logic [rcm_pkg::ROOT_W-1:0]  root;
  logic                        gmul_start, gmul_done;
  logic [P_W-1:0]              gprod;
  logic [RMS_W-1:0]            rms_sat;
  logic                        out_load;

  assign s_axis_tready_o = (state_q == rcm_pkg::ST_IDLE);
  assign s_acc           = s_axis_tvalid_i && s_axis_tready_o;

  // channel modulo CHANNELS on a 2-bit field
  always_comb begin
    ch_m = {3'b000, s_axis_tuser_i};
    for (int k = 0; k < 3; k++) begin
      if (ch_m >= 5'(CHANNELS)) ch_m = ch_m - 5'(CHANNELS);
    end
  end

  assign smp_ext = {{(rcm_pkg::IN_DATA_W - rcm_pkg::SMP_IN_W){1'b0}},
                    s_axis_tdata_i[rcm_pkg::SMP_IN_W-1:0]};

  // offset filter and error term
  always_comb begin
    scaled  = {smp_q, {FILTER_SHIFT{1'b0}}};
    off_cur = off_q[idx_q];
    diff    = {1'b0, scaled} - {1'b0, off_cur};
    dmag    = diff[OFF_W] ? OFF_W'(-diff) : diff[OFF_W-1:0];
    step    = dmag[OFF_W-1:FILTER_SHIFT];
    noff    = diff[OFF_W] ? (off_cur - OFF_W'(step)) : (off_cur + OFF_W'(step));
    fval    = {1'b0, scaled} - {1'b0, noff_q};
    fmag    = fval[OFF_W] ? OFF_W'(-fval) : fval[OFF_W-1:0];
  end

  // accumulate and burst check
  always_comb begin
    sum_add     = {1'b0, sum_q} + (SUM_W+1)'(sq_prod[SQ_SH +: SQ_W]);
    sum_new     = sum_add[SUM_W] ? {SUM_W{1'b1}} : sum_add[SUM_W-1:0];
    cnt_new     = cnt_q + CNT_W'(1);
    target      = (sample_count_q == '0) ? CNT_W'(1) : sample_count_q;
    emit        = (cnt_new == '0) || (cnt_new >= target);
    div_divisor = (cnt_new == '0) ? {1'b1, {CNT_W{1'b0}}} : {1'b0, cnt_new};
    rms_sat     = (|gprod[P_W-1:RMS_W+GF]) ? {RMS_W{1'b1}} : gprod[RMS_W+GF-1:GF];
  end

  always_comb begin
    state_d    = state_q;
    sq_start   = 1'b0;
    div_start  = 1'b0;
    sqrt_start = 1'b0;
    gmul_start = 1'b0;
    out_load   = 1'b0;
    unique case (state_q)
      rcm_pkg::ST_IDLE: begin
        if (s_acc) state_d = rcm_pkg::ST_FILT;
      end
      rcm_pkg::ST_FILT: begin
        state_d = rcm_pkg::ST_FVAL;
      end
      rcm_pkg::ST_FVAL: begin
        sq_start = 1'b1;
        state_d  = rcm_pkg::ST_SQ;
      end
      rcm_pkg::ST_SQ: begin
        if (sq_done) begin
          if (emit) begin
            div_start = 1'b1;
            state_d   = rcm_pkg::ST_DIV;
          end else begin
            state_d = rcm_pkg::ST_IDLE;
          end
        end
      end
      rcm_pkg::ST_DIV: begin
        if (div_done) begin
          sqrt_start = 1'b1;
          state_d    = rcm_pkg::ST_SQRT;
        end
      end
      rcm_pkg::ST_SQRT: begin
        if (sqrt_done) begin
          gmul_start = 1'b1;
          state_d    = rcm_pkg::ST_MUL;
        end
      end
      rcm_pkg::ST_MUL: begin
        if (gmul_done) state_d = rcm_pkg::ST_OUT;
      end
      rcm_pkg::ST_OUT: begin
        if (!m_valid_q || m_axis_tready_i) begin
          out_load = 1'b1;
          state_d  = rcm_pkg::ST_IDLE;
        end
      end
      default: state_d = rcm_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= rcm_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sample_count_q <= rcm_pkg::SAMPLE_COUNT_RST;
      current_gain_q <= rcm_pkg::CURRENT_GAIN_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        rcm_pkg::CFG_SAMPLE_COUNT: sample_count_q <= cfg_data_i[CNT_W-1:0];
        rcm_pkg::CFG_CURRENT_GAIN: current_gain_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < CHANNELS; i++) off_q[i] <= OFF_MID;
      sum_q     <= '0;
      cnt_q     <= '0;
      m_valid_q <= 1'b0;
    end else begin
      if (state_q == rcm_pkg::ST_FILT) off_q[idx_q] <= noff;
      if ((state_q == rcm_pkg::ST_SQ) && sq_done) begin
        sum_q <= emit ? '0 : sum_new;
        cnt_q <= emit ? '0 : cnt_new;
      end
      if (out_load) begin
        m_valid_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        m_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_acc) begin
      ch_q  <= s_axis_tuser_i;
      idx_q <= ch_m[IDX_W-1:0];
      smp_q <= smp_ext[SAMPLE_BITS-1:0];
    end
    if (state_q == rcm_pkg::ST_FILT) noff_q <= noff;
    if ((state_q == rcm_pkg::ST_MUL) && gmul_done) res_q <= rms_sat;
    if (out_load) begin
      m_data_q <= res_q;
      m_user_q <= ch_q;
    end
  end

  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tdata_o  = m_data_q;
  assign m_axis_tuser_o  = m_user_q;

  rcm_mul #(
    .A_W (OFF_W),
    .B_W (OFF_W)
  ) u_sq (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (sq_start),
    .a_i     (fmag),
    .b_i     (fmag),
    .done_o  (sq_done),
    .prod_o  (sq_prod)
  );

  rcm_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i ({sum_new, {rcm_pkg::FRAC_SHIFT{1'b0}}}),
    .divisor_i  (div_divisor),
    .done_o     (div_done),
    .quot_o     (div_quot)
  );

  rcm_sqrt u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (sqrt_start),
    .rad_i   (div_quot),
    .done_o  (sqrt_done),
    .root_o  (root)
  );

  rcm_mul #(
    .A_W (rcm_pkg::GAIN_W),
    .B_W (rcm_pkg::ROOT_W)
  ) u_gain (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (gmul_start),
    .a_i     (current_gain_q),
    .b_i     (root),
    .done_o  (gmul_done),
    .prod_o  (gprod)
  );

  `RCM_ASSERT_NXT(a_burst_clear, (state_q == rcm_pkg::ST_SQ) && sq_done && emit, (cnt_q == '0) && (sum_q == '0), "burst end did not clear sum and count")
  `RCM_ASSERT_NXT(a_sum_grows, (state_q == rcm_pkg::ST_SQ) && sq_done && !emit, sum_q >= $past(sum_q), "square sum decreased within a burst")
  `RCM_ASSERT_IMP(a_div_nonzero, div_start, div_divisor != '0, "divider started with zero divisor")
  `RCM_ASSERT_IMP(a_out_src, $rose(m_valid_q), $past(state_q) == rcm_pkg::ST_OUT, "output word raised outside the output state")

endmodule

[hw/rtl/rcm_mul.sv]
// Bit-serial shift-add multiplier, one multiplier bit per cycle
`timescale 1ns / 1ps
module rcm_mul #(
  parameter int A_W = 22,
  parameter int B_W = 22
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic [A_W-1:0]     a_i,
  input  logic [B_W-1:0]     b_i,
  output logic               done_o,
  output logic [A_W+B_W-1:0] prod_o
);

  localparam int P_W = A_W + B_W;
  localparam int C_W = $clog2(B_W + 1);

  logic           busy_q;
  logic           done_q;
  logic [C_W-1:0] cnt_q;
  logic [A_W-1:0] a_q;
  logic [P_W-1:0] prod_q;
  logic [P_W-1:0] prod_d;
  logic [A_W:0]   part;

  always_comb begin
    part   = {1'b0, prod_q[P_W-1:B_W]} + (prod_q[0] ? {1'b0, a_q} : '0);
    prod_d = {part, prod_q[B_W-1:1]};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= busy_q && (cnt_q == C_W'(1));
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= C_W'(B_W);
      end else if (busy_q) begin
        cnt_q <= cnt_q - C_W'(1);
        if (cnt_q == C_W'(1)) busy_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      a_q    <= a_i;
      prod_q <= {{A_W{1'b0}}, b_i};
    end else if (busy_q) begin
      prod_q <= prod_d;
    end
  end

  assign done_o = done_q;
  assign prod_o = prod_q;

endmodule

[hw/rtl/rcm_div.sv]
// Restoring divider, one quotient bit per cycle
`timescale 1ns / 1ps
module rcm_div (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic [rcm_pkg::DIV_W-1:0]     dividend_i,
  input  logic [rcm_pkg::DIVISOR_W-1:0] divisor_i,
  output logic                          done_o,
  output logic [rcm_pkg::DIV_W-1:0]     quot_o
);

  localparam int D_W = rcm_pkg::DIV_W;
  localparam int N_W = rcm_pkg::DIVISOR_W;
  localparam int C_W = $clog2(D_W + 1);

  logic           busy_q;
  logic           done_q;
  logic [C_W-1:0] cnt_q;
  logic [N_W-1:0] dvs_q;
  logic [N_W-1:0] rem_q;
  logic [N_W-1:0] rem_d;
  logic [D_W-1:0] quo_q;
  logic [D_W-1:0] quo_d;
  logic [N_W:0]   trial;
  logic [N_W:0]   diff;
  logic           ge;

  always_comb begin
    trial = {rem_q, quo_q[D_W-1]};
    diff  = trial - {1'b0, dvs_q};
    ge    = trial >= {1'b0, dvs_q};
    rem_d = ge ? diff[N_W-1:0] : trial[N_W-1:0];
    quo_d = {quo_q[D_W-2:0], ge};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= busy_q && (cnt_q == C_W'(1));
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= C_W'(D_W);
      end else if (busy_q) begin
        cnt_q <= cnt_q - C_W'(1);
        if (cnt_q == C_W'(1)) busy_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      dvs_q <= divisor_i;
      rem_q <= '0;
      quo_q <= dividend_i;
    end else if (busy_q) begin
      rem_q <= rem_d;
      quo_q <= quo_d;
    end
  end

  assign done_o = done_q;
  assign quot_o = quo_q;

endmodule

[hw/rtl/rcm_sqrt.sv]
// Digit-by-digit integer square root, one root bit per cycle
`timescale 1ns / 1ps
module rcm_sqrt (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  logic [rcm_pkg::DIV_W-1:0]  rad_i,
  output logic                       done_o,
  output logic [rcm_pkg::ROOT_W-1:0] root_o
);

  localparam int R_W   = rcm_pkg::ROOT_W;
  localparam int RAD_W = rcm_pkg::DIV_W;
  localparam int REM_W = R_W + 2;
  localparam int C_W   = $clog2(R_W + 1);

  logic             busy_q;
  logic             done_q;
  logic [C_W-1:0]   cnt_q;
  logic [RAD_W-1:0] rad_q;
  logic [REM_W-1:0] rem_q;
  logic [REM_W-1:0] rem_sh;
  logic [REM_W-1:0] trial;
  logic [REM_W-1:0] rem_d;
  logic [R_W-1:0]   root_q;
  logic [R_W-1:0]   root_d;
  logic             ge;

  always_comb begin
    rem_sh = {rem_q[REM_W-3:0], rad_q[RAD_W-1 -: 2]};
    trial  = {root_q, 2'b01};
    ge     = rem_sh >= trial;
    rem_d  = ge ? (rem_sh - trial) : rem_sh;
    root_d = {root_q[R_W-2:0], ge};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= busy_q && (cnt_q == C_W'(1));
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= C_W'(R_W);
      end else if (busy_q) begin
        cnt_q <= cnt_q - C_W'(1);
        if (cnt_q == C_W'(1)) busy_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rad_q  <= rad_i;
      rem_q  <= '0;
      root_q <= '0;
    end else if (busy_q) begin
      rad_q  <= {rad_q[RAD_W-3:0], 2'b00};
      rem_q  <= rem_d;
      root_q <= root_d;
    end
  end

  assign done_o = done_q;
  assign root_o = root_q;

endmodule

[bench/testbench.sv]
// Self-checking testbench for the rms current meter with per-channel offset tracking
`timescale 1ns / 1ps
module testbench;

  localparam int CYCLE_LIMIT   = 1_000_000;
  localparam int SETTLE_CYCLES = 200;
  localparam int MAX_PRINTS    = 100;
  localparam logic [63:0] SUM_SAT = (64'd1 << rcm_pkg::SUM_W) - 64'd1;
  localparam logic [63:0] RMS_SAT = (64'd1 << rcm_pkg::RMS_W) - 64'd1;

  typedef struct packed {
    logic [rcm_pkg::CH_IN_W-1:0]  ch;
    logic [rcm_pkg::SMP_IN_W-1:0] smp;
  } adc_word_t;

  typedef struct packed {
    logic [rcm_pkg::RMS_W-1:0]   rms;
    logic [rcm_pkg::CH_IN_W-1:0] ch;
  } rms_word_t;

  logic                            clk_i = 1'b0;
  logic                            rst_ni = 1'b0;
  logic                            s_axis_tvalid_i = 1'b0;
  logic                            s_axis_tready_o;
  logic [rcm_pkg::IN_DATA_W-1:0]   s_axis_tdata_i = '0;
  logic [rcm_pkg::CH_IN_W-1:0]     s_axis_tuser_i = '0;
  logic                            m_axis_tvalid_o;
  logic                            m_axis_tready_i = 1'b0;
  logic [rcm_pkg::OUT_DATA_W-1:0]  m_axis_tdata_o;
  logic [rcm_pkg::CH_IN_W-1:0]     m_axis_tuser_o;
  logic                            cfg_we_i = 1'b0;
  logic [rcm_pkg::CFG_IDX_W-1:0]   cfg_idx_i = '0;
  logic [rcm_pkg::CFG_DATA_W-1:0]  cfg_data_i = '0;

  rms_current_meter_offset_tracking dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tuser_i  (s_axis_tuser_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tuser_o  (m_axis_tuser_o),
    .cfg_we_i        (cfg_we_i),
    .cfg_idx_i       (cfg_idx_i),
    .cfg_data_i      (cfg_data_i)
  );

  adc_word_t   pending_samples[$];
  rms_word_t   rms_expected[$];
  adc_word_t   on_bus;
  int          idle_pct = 0;
  int          stall_pct = 0;
  int          errors = 0;
  int          cycle_count = 0;

  // shadow of the meter state and registers
  longint      offset_est[4];
  logic [63:0] sq_acc;
  logic [15:0] burst_len;
  logic [15:0] cnt_cfg;
  logic [31:0] gain_cfg;

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  function automatic logic [63:0] floor_sqrt(input logic [63:0] v);
    logic [63:0] res;
    logic [63:0] b;
    res = '0;
    b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= res + b) begin
        v -= res + b;
        res = (res >> 1) + b;
      end else begin
        res >>= 1;
      end
      b >>= 2;
    end
    return res;
  endfunction

  function automatic void reset_meter_state();
    for (int i = 0; i < 4; i++)
      offset_est[i] = longint'(1) << (rcm_pkg::SMP_IN_W - 1 + 10);
    sq_acc    = '0;
    burst_len = '0;
    cnt_cfg   = rcm_pkg::SAMPLE_COUNT_RST;
    gain_cfg  = rcm_pkg::CURRENT_GAIN_RST;
  endfunction

  // offset filter, square accumulation and end-of-burst rms
  function automatic void track_and_accumulate(input adc_word_t w);
    longint      scaled;
    longint      err;
    longint      f;
    logic [63:0] mag;
    logic [63:0] n;
    logic [63:0] root;
    logic [63:0] prod;
    int unsigned tgt;
    rms_word_t   r;
    scaled = longint'({w.smp, 10'd0});
    err = scaled - offset_est[w.ch];
    if (err >= 0) offset_est[w.ch] += err >>> 10;
    else offset_est[w.ch] -= (-err) >>> 10;
    f = scaled - offset_est[w.ch];
    mag = (f < 0) ? 64'(-f) : 64'(f);
    sq_acc += (mag * mag) >> 16;
    if (sq_acc > SUM_SAT) sq_acc = SUM_SAT;
    burst_len = burst_len + 16'd1;
    tgt = (cnt_cfg == 0) ? 1 : cnt_cfg;
    if (burst_len != 0 && burst_len < tgt) return;
    n = (burst_len == 0) ? 64'd65536 : 64'(burst_len);
    root = floor_sqrt((sq_acc << 12) / n);
    prod = (root * 64'(gain_cfg)) >> 16;
    if (prod > RMS_SAT) prod = RMS_SAT;
    r.rms = prod[rcm_pkg::RMS_W-1:0];
    r.ch  = w.ch;
    rms_expected.push_back(r);
    sq_acc    = '0;
    burst_len = '0;
  endfunction

  task automatic flag_mismatch(input string msg);
    errors++;
    if (errors <= MAX_PRINTS) $display("[%0t] mismatch: %s", $time, msg);
  endtask

  // sample word driver
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      s_axis_tvalid_i <= 1'b0;
    end else begin
      if (s_axis_tvalid_i && s_axis_tready_o) track_and_accumulate(on_bus);
      if (!s_axis_tvalid_i || s_axis_tready_o) begin
        if (pending_samples.size() != 0 && $urandom_range(99) >= idle_pct) begin
          on_bus = pending_samples.pop_front();
          s_axis_tvalid_i <= 1'b1;
          s_axis_tdata_i  <= rcm_pkg::IN_DATA_W'(on_bus.smp);
          s_axis_tuser_i  <= on_bus.ch;
        end else begin
          s_axis_tvalid_i <= 1'b0;
        end
      end
    end
  end

  // result word monitor
  always @(posedge clk_i) begin
    rms_word_t want;
    if (!rst_ni) begin
      m_axis_tready_i <= 1'b0;
    end else begin
      if (m_axis_tvalid_o && m_axis_tready_i) begin
        if (rms_expected.size() == 0) begin
          flag_mismatch($sformatf("unexpected result rms=%0h ch=%0d",
                                  m_axis_tdata_o, m_axis_tuser_o));
        end else begin
          want = rms_expected.pop_front();
          if (m_axis_tdata_o[rcm_pkg::RMS_W-1:0] !== want.rms)
            flag_mismatch($sformatf("rms_value got %0h want %0h",
                                    m_axis_tdata_o[rcm_pkg::RMS_W-1:0], want.rms));
          if (m_axis_tuser_o !== want.ch)
            flag_mismatch($sformatf("result_channel got %0d want %0d",
                                    m_axis_tuser_o, want.ch));
        end
      end
      m_axis_tready_i <= ($urandom_range(99) >= stall_pct);
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("CHECK FAILED");
      $finish;
    end
  end

  task automatic push_sample(input logic [rcm_pkg::CH_IN_W-1:0] ch,
                             input logic [rcm_pkg::SMP_IN_W-1:0] smp);
    adc_word_t w;
    w.ch  = ch;
    w.smp = smp;
    pending_samples.push_back(w);
  endtask

  // wait until every queued word went in and every result came out
  task automatic drain();
    do @(negedge clk_i);
    while (pending_samples.size() != 0 || s_axis_tvalid_i || rms_expected.size() != 0);
  endtask

  // covers a sample still in the core that closes no burst
  task automatic settle();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [rcm_pkg::CFG_IDX_W-1:0] idx,
                           input logic [rcm_pkg::CFG_DATA_W-1:0] val);
    @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    if (idx == rcm_pkg::CFG_SAMPLE_COUNT) cnt_cfg = val[15:0];
    else gain_cfg = val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic random_phase(input int n_items);
    int          tgt;
    int          blen;
    int          ctr;
    int          amp;
    int          v;
    int          sel;
    int          k;
    bit          paused;
    logic [1:0]  ch;
    logic [15:0] cnt;
    logic [31:0] gn;
    drain();
    settle();
    sel = $urandom_range(9);
    if (sel == 0) cnt = '0;
    else if (sel == 9) cnt = 16'd1;
    else if (sel < 7) cnt = 16'($urandom_range(12, 2));
    else cnt = 16'($urandom_range(48, 13));
    sel = $urandom_range(7);
    case (sel)
      0: gn = '0;
      1: gn = '1;
      2: gn = $urandom;
      default: gn = $urandom_range(32'h000F_FFFF, 32'h0000_1000);
    endcase
    write_reg(rcm_pkg::CFG_SAMPLE_COUNT, 32'(cnt));
    write_reg(rcm_pkg::CFG_CURRENT_GAIN, gn);
    tgt = (cnt == 0) ? 1 : int'(cnt);
    k = 0;
    paused = 0;
    while (k < n_items) begin
      blen = tgt;
      if ($urandom_range(99) < 15) blen = $urandom_range(2 * tgt, 1);
      ch  = 2'($urandom_range(3));
      ctr = $urandom_range(4095);
      amp = $urandom_range(2047);
      repeat (blen) begin
        sel = $urandom_range(9);
        if (sel == 0) begin
          v = $urandom_range(4095);
        end else if (sel == 1) begin
          v = $urandom_range(1) ? 4095 : 0;
        end else begin
          v = ctr + int'($urandom_range(2 * amp)) - amp;
          if (v < 0) v = 0;
          if (v > 4095) v = 4095;
        end
        push_sample(($urandom_range(99) < 8) ? 2'($urandom_range(3)) : ch, 12'(v));
        k++;
        if (!paused && k >= n_items / 2) begin
          drain();
          paused = 1;
        end
      end
    end
  endtask

  initial begin
    reset_meter_state();
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    // reset register values, then count lowered mid-burst to zero (acts as one)
    push_sample(2'd0, 12'd0);
    push_sample(2'd0, 12'd4095);
    push_sample(2'd1, 12'd4095);
    push_sample(2'd2, 12'd0);
    push_sample(2'd3, 12'd2047);
    drain();
    settle();
    write_reg(rcm_pkg::CFG_SAMPLE_COUNT, 32'd0);
    push_sample(2'd3, 12'd4095);
    push_sample(2'd1, 12'd0);
    drain();
    settle();

    // full-scale gain, rms saturation
    write_reg(rcm_pkg::CFG_CURRENT_GAIN, 32'hFFFF_FFFF);
    push_sample(2'd0, 12'd4095);
    push_sample(2'd0, 12'd0);
    push_sample(2'd2, 12'd4095);
    push_sample(2'd3, 12'd0);
    drain();
    settle();

    // zero gain, count of one
    write_reg(rcm_pkg::CFG_CURRENT_GAIN, 32'd0);
    write_reg(rcm_pkg::CFG_SAMPLE_COUNT, 32'd1);
    push_sample(2'd1, 12'd1234);
    push_sample(2'd2, 12'd4095);
    drain();
    settle();

    // largest count, then lowered below the samples already gathered
    write_reg(rcm_pkg::CFG_SAMPLE_COUNT, 32'd65535);
    write_reg(rcm_pkg::CFG_CURRENT_GAIN, 32'h0001_0000);
    push_sample(2'd2, 12'd0);
    push_sample(2'd2, 12'd4095);
    push_sample(2'd1, 12'd0);
    push_sample(2'd2, 12'd4095);
    push_sample(2'd2, 12'd2048);
    push_sample(2'd0, 12'd1);
    drain();
    settle();
    write_reg(rcm_pkg::CFG_SAMPLE_COUNT, 32'd2);
    push_sample(2'd2, 12'd0);
    push_sample(2'd2, 12'd4095);
    push_sample(2'd2, 12'd0);
    drain();
    settle();

    // ordinary burst
    write_reg(rcm_pkg::CFG_SAMPLE_COUNT, 32'd3);
    push_sample(2'd1, 12'd3000);
    push_sample(2'd1, 12'd1000);
    push_sample(2'd1, 12'd2900);

    for (int mode = 0; mode < 4; mode++) begin
      drain();
      case (mode)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 63; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 63; end
        default: begin idle_pct = 18; stall_pct = 18; end
      endcase
      repeat (6) random_phase(60);
    end

    drain();
    settle();
    if (rms_expected.size() != 0)
      flag_mismatch($sformatf("%0d results never arrived", rms_expected.size()));
    if (errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
